// File: src/lrss_pkg.sv
// ----------------------------------------------------------------------------
// Looping random shift sequencer package
// Field widths, fixed constants, codes and the xorshift step shared by the
// sequencer core, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package lrss_pkg;

	localparam int KNOB_W     = 12;
	localparam int VOLT_W     = 12;
	localparam int PAT_W      = 16;
	localparam int GEN_W      = 32;
	localparam int LEN_W      = 5;
	localparam int CHANCE_W   = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [GEN_W-1:0] SEED_FALLBACK = 32'hA5A5_A5A5;
	localparam logic [GEN_W-1:0] GEN_RESET     = 32'h0123_4567;
	localparam logic [GEN_W-1:0] SEED_RESET    = 32'h00C0_FFEE;

	// Knob values up to this point never slip.
	localparam logic [KNOB_W-1:0] LOCK_ZONE = 12'd200;

	// (knob - 200) * 4096 / 3895 is exact as a multiply by this reciprocal
	// followed by a right shift, over the whole knob range.
	localparam int               LIN_RECIP_W = 25;
	localparam logic [LIN_RECIP_W-1:0] LIN_RECIP = 25'd17642998;
	localparam int               LIN_SHIFT   = 24;

	// byte * 4095 / 255 equals byte * 16 + byte / 17, and byte / 17 is
	// byte * 241 >> 12 for every byte value.
	localparam logic [7:0] DIV17_RECIP = 8'd241;
	localparam int         DIV17_SHIFT = 12;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_INIT = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_LENGTH = 1'b0,
		REG_SEED_WORD   = 1'b1
	} cfg_reg_t;

	function automatic logic [GEN_W-1:0] xorshift32(input logic [GEN_W-1:0] x);
		logic [GEN_W-1:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

endpackage

// File: src/lrss_ifs.sv
// ----------------------------------------------------------------------------
// Looping random shift sequencer channels
// Valid/ready channel interfaces for the request and the result words.
// ----------------------------------------------------------------------------
interface lrss_req_if import lrss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [KNOB_W-1:0] change_knob;

	modport source (output valid, output action, output change_knob, input ready);
	modport sink (input valid, input action, input change_knob, output ready);
endinterface

interface lrss_rsp_if import lrss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VOLT_W-1:0] voltage_value;
	logic [PAT_W-1:0]  pattern_bits;
	logic              slipped;

	modport source (output valid, output voltage_value, output pattern_bits,
		output slipped, input ready);
	modport sink (input valid, input voltage_value, input pattern_bits,
		input slipped, output ready);
endinterface

// File: src/looping_random_shift_sequencer_core.sv
// ----------------------------------------------------------------------------
// Looping random shift sequencer core
// A 16-bit looping shift register whose fed-back bit can slip at random under
// an xorshift32 generator. A tick word shifts the register and recirculates
// bit loop_length-1, replacing it by a random bit with a probability set by
// the change knob (never up to 200, always at 4095). An init word reseeds the
// generator from seed_word (zero picks a fixed seed) and refills the register
// from one draw. Each word gives one result: the register, its low byte
// scaled to 0..4095, and whether the tick slipped. One word is taken every
// cycle while the result channel does not stall; a result passes through two
// knob stages (scaling multiply, then square), then the stage that steps
// the generator and the register, and the result register.
// ----------------------------------------------------------------------------
module looping_random_shift_sequencer_core import lrss_pkg::*; #(
	parameter int MIN_LENGTH = 2,
	parameter int MAX_LENGTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lrss_req_if.sink              req,
	lrss_rsp_if.source            rsp
);

	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(MIN_LENGTH);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LENGTH);
	localparam logic [LEN_W-1:0] LEN_RESET = (8 < MIN_LENGTH) ? LEN_MIN :
		((8 > MAX_LENGTH) ? LEN_MAX : LEN_W'(8));

	// Configuration registers.
	logic [LEN_W-1:0]  loop_q;
	logic [GEN_W-1:0]  seed_q;
	logic [LEN_W-1:0]  len_wr;
	logic [LEN_W-1:0]  len_clamped;

	// Pipeline stages.
	logic                v_s1, v_s2, v_s3;
	action_t             act_s1, act_s2, act_s3;
	logic [KNOB_W-1:0]   knob_s1;
	logic [CHANCE_W-1:0] lin_s2;
	logic [CHANCE_W-1:0] chance_s3;

	// Sequencer state and result register.
	logic [GEN_W-1:0]  gen_q;
	logic [PAT_W-1:0]  shift_q;
	logic              rsp_v_q;
	logic [VOLT_W-1:0] volt_q;
	logic [PAT_W-1:0]  pat_q;
	logic              slip_q;

	logic out_load, s3_en, s2_en, s1_en, commit;

	logic [KNOB_W-1:0]                   knob_ofs;
	logic [KNOB_W+LIN_RECIP_W-1:0]       lin_prod;
	logic [CHANCE_W-1:0]                 lin_nxt;
	logic [2*CHANCE_W-1:0]               sq_prod;

	logic [GEN_W-1:0]  draw1, draw2, seed_pick, init_draw;
	logic [LEN_W-1:0]  len_m1;
	logic [3:0]        tap_idx;
	logic              tick_slip;
	logic              fed;
	logic [GEN_W-1:0]  gen_nxt;
	logic [PAT_W-1:0]  shift_nxt;
	logic              slip_nxt;
	logic [15:0]       div17_prod;
	logic [VOLT_W-1:0] volt_nxt;

	// Each stage moves when the one after it is empty or moving.
	assign out_load  = !rsp_v_q || rsp.ready;
	assign s3_en     = !v_s3 || out_load;
	assign s2_en     = !v_s2 || s3_en;
	assign s1_en     = !v_s1 || s2_en;
	assign req.ready = s1_en;
	assign commit    = v_s3 && out_load;

	// Configuration writes.
	assign len_wr      = cfg_data[LEN_W-1:0];
	assign len_clamped = (len_wr < LEN_MIN) ? LEN_MIN :
		((len_wr > LEN_MAX) ? LEN_MAX : len_wr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= LEN_RESET;
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOOP_LENGTH: loop_q <= len_clamped;
				REG_SEED_WORD:   seed_q <= cfg_data[GEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Knob scaling: linear map of the knob above the lock zone to 0..4096.
	assign knob_ofs = knob_s1 - LOCK_ZONE;
	assign lin_prod = (KNOB_W+LIN_RECIP_W)'(knob_ofs) * (KNOB_W+LIN_RECIP_W)'(LIN_RECIP);
	assign lin_nxt  = (knob_s1 > LOCK_ZONE) ?
		lin_prod[LIN_SHIFT+CHANCE_W-1:LIN_SHIFT] : '0;

	// The square is at most 2^24, so shifted right by 12 it fits 13 bits.
	assign sq_prod = lin_s2 * lin_s2;

	// Generator and register step.
	assign draw1     = xorshift32(gen_q);
	assign draw2     = xorshift32(draw1);
	assign seed_pick = (seed_q != '0) ? seed_q : SEED_FALLBACK;
	assign init_draw = xorshift32(seed_pick);
	assign len_m1    = loop_q - LEN_W'(1);
	assign tap_idx   = len_m1[3:0];
	assign tick_slip = {1'b0, draw1[11:0]} < chance_s3;

	always_comb begin
		fed = 1'b0;
		case (act_s3)
			ACT_INIT: begin
				gen_nxt   = init_draw;
				shift_nxt = init_draw[PAT_W-1:0];
				slip_nxt  = 1'b0;
			end
			default: begin
				fed       = tick_slip ? draw2[0] : shift_q[tap_idx];
				gen_nxt   = tick_slip ? draw2 : draw1;
				shift_nxt = {shift_q[PAT_W-2:0], fed};
				slip_nxt  = tick_slip;
			end
		endcase
	end

	assign div17_prod = 16'(shift_nxt[7:0]) * 16'(DIV17_RECIP);
	assign volt_nxt   = {shift_nxt[7:0], div17_prod[DIV17_SHIFT+3:DIV17_SHIFT]};

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			rsp_v_q <= 1'b0;
			gen_q   <= GEN_RESET;
			shift_q <= '0;
		end else begin
			if (s1_en) begin
				v_s1 <= req.valid;
			end
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (s3_en) begin
				v_s3 <= v_s2;
			end
			if (out_load) begin
				rsp_v_q <= v_s3;
			end
			if (commit) begin
				gen_q   <= gen_nxt;
				shift_q <= shift_nxt;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s1_en) begin
			act_s1  <= action_t'(req.action);
			knob_s1 <= req.change_knob;
		end
		if (s2_en) begin
			act_s2 <= act_s1;
			lin_s2 <= lin_nxt;
		end
		if (s3_en) begin
			act_s3    <= act_s2;
			chance_s3 <= sq_prod[DIV17_SHIFT+CHANCE_W-1:DIV17_SHIFT];
		end
		if (commit) begin
			volt_q <= volt_nxt;
			pat_q  <= shift_nxt;
			slip_q <= slip_nxt;
		end
	end

	assign rsp.valid         = rsp_v_q;
	assign rsp.voltage_value = volt_q;
	assign rsp.pattern_bits  = pat_q;
	assign rsp.slipped       = slip_q;

endmodule

// File: src/lrss_checker.sv
// ----------------------------------------------------------------------------
// Looping random shift sequencer checker
// Port-level properties of the sequencer core, bound to every instance.
// ----------------------------------------------------------------------------
module lrss_checker import lrss_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [VOLT_W-1:0] rsp_voltage,
	input logic [PAT_W-1:0]  rsp_pattern,
	input logic              rsp_slipped
);

	// A stalled result word keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_voltage) &&
		$stable(rsp_pattern) && $stable(rsp_slipped))
		else $error("result word changed while stalled");

	// With the result register empty, nothing in the pipeline can block input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request not ready while result register is empty");

	// The scaled voltage carries the low pattern byte in its top eight bits.
	a_volt_scale: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_voltage[VOLT_W-1:4] == rsp_pattern[7:0])
		else $error("voltage does not match pattern low byte");

endmodule

bind looping_random_shift_sequencer_core lrss_checker u_lrss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_voltage (rsp.voltage_value),
	.rsp_pattern (rsp.pattern_bits),
	.rsp_slipped (rsp.slipped)
);
